/* sv/pctd_pkg.sv */
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types and constants for the trial-division prime counter.
// ----------------------------------------------------------------------------
package pctd_pkg;

	localparam int LIMIT_BITS_DEF = 16;
	localparam int COUNT_BITS     = 13;

	// 6k +- 1 divisor walk
	localparam int FIRST_DIV  = 5;
	localparam int FIRST_SQ   = 25;
	localparam int DIV_STEP   = 6;
	localparam int DIV_PAIR   = 2;
	localparam int SMALL_DIV  = 3;
	localparam int SMALL_PRIME_MAX = 3;
	localparam int FIRST_CAND = 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAND,
		ST_TEST,
		ST_MODA,
		ST_WAITA,
		ST_MODB,
		ST_WAITB,
		ST_NEXT,
		ST_DONE
	} pctd_state_t;

	// status from the remainder unit back to the sequencer
	typedef struct packed {
		logic done;
		logic zero;
	} pctd_mod_stat_t;

endpackage

/* sv/pctd_mod_unit.sv */
// ----------------------------------------------------------------------------
// pctd_mod_unit
// Bit-serial restoring remainder unit: dividend % divisor, one quotient bit
// per cycle. Flags a zero remainder.
// ----------------------------------------------------------------------------
module pctd_mod_unit
	import pctd_pkg::*;
#(
	parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [LIMIT_BITS-1:0] dividend,
	input  logic [LIMIT_BITS-1:0] divisor,
	output pctd_mod_stat_t        stat
);

	localparam int CW = $clog2(LIMIT_BITS + 1);

	logic [LIMIT_BITS-1:0] rem_q;
	logic [LIMIT_BITS-1:0] dvd_q;
	logic [LIMIT_BITS-1:0] dsr_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [LIMIT_BITS:0]   shifted;
	logic [LIMIT_BITS:0]   diff;
	logic                  fits;

	assign shifted = {rem_q, dvd_q[LIMIT_BITS-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(LIMIT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[LIMIT_BITS-1:0] : shifted[LIMIT_BITS-1:0];
			dvd_q <= {dvd_q[LIMIT_BITS-2:0], 1'b0};
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

/* sv/pctd_ctrl.sv */
// ----------------------------------------------------------------------------
// pctd_ctrl
// Sequencer: walks candidates 2..limit, screens small values, evens and
// multiples of 3 (running residue mod 3), issues trial divisions by d, d+2
// (d = 5, 11, ...) while d*d <= n, and counts the primes found.
// ----------------------------------------------------------------------------
module pctd_ctrl
	import pctd_pkg::*;
#(
	parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [LIMIT_BITS-1:0] lim,
	input  logic                  out_free,
	input  pctd_mod_stat_t        mod_stat,
	output logic                  idle,
	output logic                  mod_start,
	output logic [LIMIT_BITS-1:0] mod_dividend,
	output logic [LIMIT_BITS-1:0] mod_divisor,
	output logic                  done,
	output logic [COUNT_BITS-1:0] count
);

	localparam int SW = LIMIT_BITS + 2;

	pctd_state_t           state_q, state_d;
	logic [LIMIT_BITS-1:0] lim_q;
	logic [LIMIT_BITS-1:0] n_q;
	logic [1:0]            r3_q;
	logic [LIMIT_BITS-1:0] d_q;
	logic [SW-1:0]         dsq_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mod_start   = 1'b0;
		mod_divisor = d_q;
		found       = 1'b0;
		done        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (lim < LIMIT_BITS'(FIRST_CAND)) ? ST_DONE : ST_CAND;
				end
			end
			ST_CAND: begin
				if (n_q <= LIMIT_BITS'(SMALL_PRIME_MAX)) begin
					found   = 1'b1;
					state_d = ST_NEXT;
				end else if (!n_q[0] || r3_q == 2'd0) begin
					state_d = ST_NEXT;
				end else begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (dsq_q > SW'(n_q)) begin
					found   = 1'b1;
					state_d = ST_NEXT;
				end else begin
					state_d = ST_MODA;
				end
			end
			ST_MODA: begin
				mod_start = 1'b1;
				state_d   = ST_WAITA;
			end
			ST_WAITA: begin
				if (mod_stat.done) begin
					state_d = mod_stat.zero ? ST_NEXT : ST_MODB;
				end
			end
			ST_MODB: begin
				mod_start   = 1'b1;
				mod_divisor = d_q + LIMIT_BITS'(DIV_PAIR);
				state_d     = ST_WAITB;
			end
			ST_WAITB: begin
				if (mod_stat.done) begin
					state_d = mod_stat.zero ? ST_NEXT : ST_TEST;
				end
			end
			ST_NEXT: begin
				state_d = (n_q == lim_q) ? ST_DONE : ST_CAND;
			end
			ST_DONE: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			lim_q <= lim;
			n_q   <= LIMIT_BITS'(FIRST_CAND);
			r3_q  <= 2'(FIRST_CAND % SMALL_DIV);
			cnt_q <= '0;
		end
		if (found && cnt_q != '1) begin
			cnt_q <= cnt_q + COUNT_BITS'(1);
		end
		if (state_q == ST_CAND) begin
			d_q   <= LIMIT_BITS'(FIRST_DIV);
			dsq_q <= SW'(FIRST_SQ);
		end
		// (d+6)^2 = d^2 + 12d + 36
		if (state_q == ST_WAITB && mod_stat.done && !mod_stat.zero) begin
			d_q   <= d_q + LIMIT_BITS'(DIV_STEP);
			dsq_q <= dsq_q + (SW'(d_q) << 3) + (SW'(d_q) << 2)
				+ SW'(DIV_STEP * DIV_STEP);
		end
		// n mod 3 follows n
		if (state_q == ST_NEXT && n_q != lim_q) begin
			n_q  <= n_q + LIMIT_BITS'(1);
			r3_q <= (r3_q == 2'(SMALL_DIV - 1)) ? 2'd0 : r3_q + 2'd1;
		end
	end

	assign idle         = (state_q == ST_IDLE);
	assign mod_dividend = n_q;
	assign count        = cnt_q;

endmodule

/* sv/prime_count_trial_division_unit.sv */
// Work: one trial division at a time on the remainder unit, summed over all
//   candidates 2..limit (at most about limit * sqrt(limit) / 9 divisions); for
//   a limit below 2 no candidate is tested and the sequencer goes straight to done.
// Throughput: one item at a time, as in_ready is high only while the sequencer
//   is idle; a finished count waits in the sequencer while the output is full.
// Reset: arst_n clears the sequencer, the remainder unit's control and the
//   output valid; no stored data.
// ----------------------------------------------------------------------------
// prime_count_trial_division_unit
// Counts primes in 2..limit by 6k +- 1 trial division on a shared remainder
// unit. The result sits in an output register so a new item can be taken.
// ----------------------------------------------------------------------------
module prime_count_trial_division_unit
	import pctd_pkg::*;
#(
	parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LIMIT_BITS-1:0] limit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COUNT_BITS-1:0] prime_count
);

	pctd_mod_stat_t        mod_stat;
	logic                  idle;
	logic                  mod_start;
	logic [LIMIT_BITS-1:0] mod_dividend;
	logic [LIMIT_BITS-1:0] mod_divisor;
	logic                  done;
	logic [COUNT_BITS-1:0] count;
	logic                  out_free;
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] prime_count_q;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = idle;

	pctd_ctrl #(
		.LIMIT_BITS(LIMIT_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_valid),
		.lim          (limit),
		.out_free     (out_free),
		.mod_stat     (mod_stat),
		.idle         (idle),
		.mod_start    (mod_start),
		.mod_dividend (mod_dividend),
		.mod_divisor  (mod_divisor),
		.done         (done),
		.count        (count)
	);

	pctd_mod_unit #(
		.LIMIT_BITS(LIMIT_BITS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.stat     (mod_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			prime_count_q <= count;
		end
	end

	assign out_valid   = out_valid_q;
	assign prime_count = prime_count_q;

endmodule
